// ===== rtl/core/pd_pkg.sv =====
// Shared types, constants and helpers for the percent decoder.
package pd_pkg;

    localparam logic [7:0] PCT_CHAR = 8'h25;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } phase_t;

    // One queued request: one or two results. A second result is always a
    // valid byte that closes the string.
    typedef struct packed {
        logic       two;
        logic [7:0] char0;
        logic       valid0;
        logic       final0;
        logic [7:0] char1;
    } req_t;

    // {is_hex, nibble}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/pd_front.sv =====
// Front end: escape phase tracking and classification of each input byte.
module pd_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    char_in,
    input  logic          end_of_string,
    output logic          req_valid,
    output pd_pkg::req_t  req
);
    import pd_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [7:0] held_reg, held_next;
    logic [4:0] hi, lo;

    assign hi = hex_decode(held_reg);
    assign lo = hex_decode(char_in);

    always_comb
    begin
        phase_next = PH_IDLE;
        held_next  = held_reg;
        req_valid  = 1'b0;
        req        = '0;
        case (phase_reg)
            PH_PCT:
            begin
                if (end_of_string)
                begin
                    req_valid  = 1'b1;
                    req.two    = 1'b1;
                    req.char0  = PCT_CHAR;
                    req.valid0 = 1'b1;
                    req.char1  = char_in;
                end
                else
                begin
                    held_next  = char_in;
                    phase_next = PH_DIGIT;
                end
            end
            PH_DIGIT:
            begin
                if (hi[4] && lo[4])
                begin
                    req_valid  = 1'b1;
                    req.char0  = {hi[3:0], lo[3:0]};
                    req.valid0 = 1'b1;
                    req.final0 = end_of_string;
                end
                else if (end_of_string)
                begin
                    req_valid  = 1'b1;
                    req.final0 = 1'b1;
                end
            end
            default:
            begin
                if (char_in == PCT_CHAR && !end_of_string)
                begin
                    phase_next = PH_PCT;
                end
                else
                begin
                    req_valid  = 1'b1;
                    req.char0  = char_in;
                    req.valid0 = 1'b1;
                    req.final0 = end_of_string;
                end
            end
        endcase
        if (!accept)
        begin
            phase_next = phase_reg;
            held_next  = held_reg;
            req_valid  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            held_reg  <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

// ===== rtl/core/pd_queue.sv =====
// Short request queue between front and back ends.
module pd_queue #(
    parameter int DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  pd_pkg::req_t  wr_data,
    output logic          full,
    input  logic          rd_en,
    output pd_pkg::req_t  rd_data,
    output logic          not_empty
);
    import pd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    req_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_wr, do_rd;

    assign full      = (cnt_reg == CW'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign do_wr     = wr_en && !full;
    assign do_rd     = rd_en && not_empty;
    assign rd_data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== rtl/core/pd_back.sv =====
// Back end: expands queued requests into results and holds the output register.
module pd_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_avail,
    input  pd_pkg::req_t  req,
    output logic          req_take,
    output logic          empty,
    input  logic          pop,
    output logic [7:0]    char_out,
    output logic          char_valid,
    output logic          final_item
);
    import pd_pkg::*;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] char_reg, char_next;
    logic       cvalid_reg, cvalid_next;
    logic       final_reg, final_next;
    logic       sel_reg, sel_next;
    logic       load;

    assign load = req_avail && (!out_valid_reg || pop);

    always_comb
    begin
        out_valid_next = out_valid_reg && !pop;
        char_next      = char_reg;
        cvalid_next    = cvalid_reg;
        final_next     = final_reg;
        sel_next       = sel_reg;
        req_take       = 1'b0;
        if (load)
        begin
            out_valid_next = 1'b1;
            if (sel_reg)
            begin
                char_next   = req.char1;
                cvalid_next = 1'b1;
                final_next  = 1'b1;
                sel_next    = 1'b0;
                req_take    = 1'b1;
            end
            else
            begin
                char_next   = req.char0;
                cvalid_next = req.valid0;
                final_next  = req.final0;
                sel_next    = req.two;
                req_take    = !req.two;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sel_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            sel_reg       <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg   <= char_next;
        cvalid_reg <= cvalid_next;
        final_reg  <= final_next;
    end

    assign empty      = !out_valid_reg;
    assign char_out   = char_reg;
    assign char_valid = cvalid_reg;
    assign final_item = final_reg;

endmodule

// ===== rtl/core/percent_decoder.sv =====
// Top level of the streaming URL percent decoder.
// Path: an accepted request is written into the queue, then into the output register
// once that is empty or being popped, and the receiver pops it from there.
// Throughput: one input byte per cycle while not full; results leave at one per cycle
// while popped, so a cut-short escape's two results hold the back end for both.
// Reset: rst_n clears escape phase, queue and output register asynchronously.
module percent_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] char_in,
    input  logic       end_of_string,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] char_out,
    output logic       char_valid,
    output logic       final_item
);
    import pd_pkg::*;

    logic accept;
    logic fr_valid;
    req_t fr_req;
    logic q_avail;
    req_t q_req;
    logic q_take;

    assign accept = push && !full;

    pd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .char_in       (char_in),
        .end_of_string (end_of_string),
        .req_valid     (fr_valid),
        .req           (fr_req)
    );

    pd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (fr_valid),
        .wr_data   (fr_req),
        .full      (full),
        .rd_en     (q_take),
        .rd_data   (q_req),
        .not_empty (q_avail)
    );

    pd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_avail  (q_avail),
        .req        (q_req),
        .req_take   (q_take),
        .empty      (empty),
        .pop        (pop),
        .char_out   (char_out),
        .char_valid (char_valid),
        .final_item (final_item)
    );

endmodule

// ===== tb/sv/percent_decoder_checker.sv =====
// Checker for the percent decoder: predicts decoded bytes and compares them at the result port.
module percent_decoder_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic       full,
    input  logic [7:0] char_in,
    input  logic       end_of_string,
    input  logic       empty,
    input  logic       pop,
    input  logic [7:0] char_out,
    input  logic       char_valid,
    input  logic       final_item,
    output int         errors,
    output int         outstanding,
    output int         checked
);
    import pd_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       valid;
        logic       fin;
    } decoded_t;

    decoded_t   decoded_q[$];
    phase_t     esc_phase;
    logic [7:0] first_digit;
    int         err_cnt;
    int         check_cnt;

    // {is_hex, value}
    function automatic logic [4:0] nibble(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
        begin
            return {1'b1, c[3:0]};
        end
        if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
        begin
            return {1'b1, c[3:0] + 4'd9};
        end
        return 5'd0;
    endfunction

    task automatic add_decoded(input logic [7:0] ch, input logic valid, input logic fin);
        decoded_t d;
        d.ch    = ch;
        d.valid = valid;
        d.fin   = fin;
        decoded_q.push_back(d);
    endtask

    task automatic decode_byte(input logic [7:0] c, input logic eos);
        logic [4:0] hi;
        logic [4:0] lo;
        hi = nibble(first_digit);
        lo = nibble(c);
        case (esc_phase)
            PH_PCT:
            begin
                if (eos)
                begin
                    add_decoded(PCT_CHAR, 1'b1, 1'b0);
                    add_decoded(c, 1'b1, 1'b1);
                    esc_phase = PH_IDLE;
                end
                else
                begin
                    first_digit = c;
                    esc_phase   = PH_DIGIT;
                end
            end
            PH_DIGIT:
            begin
                if (hi[4] && lo[4])
                begin
                    add_decoded({hi[3:0], lo[3:0]}, 1'b1, eos);
                end
                else if (eos)
                begin
                    add_decoded(8'h00, 1'b0, 1'b1);
                end
                esc_phase = PH_IDLE;
            end
            default:
            begin
                esc_phase = PH_IDLE;
                if (c == PCT_CHAR)
                begin
                    if (eos)
                    begin
                        add_decoded(c, 1'b1, 1'b1);
                    end
                    else
                    begin
                        esc_phase = PH_PCT;
                    end
                end
                else
                begin
                    add_decoded(c, 1'b1, eos);
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        decoded_t want;
        if (!rst_n)
        begin
            decoded_q.delete();
            esc_phase   = PH_IDLE;
            first_digit = 8'h00;
            outstanding <= 0;
        end
        else
        begin
            // results first: nothing accepted at this edge can leave at the same edge
            if (pop && !empty)
            begin
                if (decoded_q.size() == 0)
                begin
                    $error("unexpected result: char_out=%h char_valid=%b final_item=%b",
                           char_out, char_valid, final_item);
                    err_cnt++;
                end
                else
                begin
                    want = decoded_q.pop_front();
                    check_cnt++;
                    if (char_out !== want.ch)
                    begin
                        $error("char_out: expected %h, got %h", want.ch, char_out);
                        err_cnt++;
                    end
                    if (char_valid !== want.valid)
                    begin
                        $error("char_valid: expected %b, got %b", want.valid, char_valid);
                        err_cnt++;
                    end
                    if (final_item !== want.fin)
                    begin
                        $error("final_item: expected %b, got %b", want.fin, final_item);
                        err_cnt++;
                    end
                end
            end
            if (push && !full)
            begin
                decode_byte(char_in, end_of_string);
            end
            outstanding <= decoded_q.size();
            errors      <= err_cnt;
            checked     <= check_cnt;
        end
    end

endmodule

// ===== tb/sv/tb_percent_decoder.sv =====
// Testbench top for the percent decoder: reset, byte stimulus, receiver, watchdog and verdict.
module tb_percent_decoder;
    import pd_pkg::*;

    localparam int N_RANDOM       = 850;
    localparam int RX_HOLD_CYCLES = 80;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 1000;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       push          = 1'b0;
    logic       pop           = 1'b0;
    logic [7:0] char_in       = 8'h00;
    logic       end_of_string = 1'b0;
    logic       full;
    logic       empty;
    logic [7:0] char_out;
    logic       char_valid;
    logic       final_item;

    int errors;
    int outstanding;
    int checked;

    int         bytes_sent    = 0;
    int         strings_sent  = 0;
    int         hold_requests = 0;
    bit         quiet         = 1'b0;
    int         quiet_cycles  = 0;
    logic [7:0] text[$];

    always #4 clk = ~clk;

    percent_decoder DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .char_in       (char_in),
        .end_of_string (end_of_string),
        .empty         (empty),
        .pop           (pop),
        .char_out      (char_out),
        .char_valid    (char_valid),
        .final_item    (final_item)
    );

    percent_decoder_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .char_in       (char_in),
        .end_of_string (end_of_string),
        .empty         (empty),
        .pop           (pop),
        .char_out      (char_out),
        .char_valid    (char_valid),
        .final_item    (final_item),
        .errors        (errors),
        .outstanding   (outstanding),
        .checked       (checked)
    );

    // receiver: random idling, plus a long hold-off on request
    initial
    begin
        int holds_served;
        int hold_left;
        holds_served = 0;
        hold_left    = 0;
        forever
        begin
            @(negedge clk);
            if (holds_served != hold_requests)
            begin
                holds_served = hold_requests;
                hold_left    = RX_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                pop <= 1'b0;
                hold_left--;
            end
            else
            begin
                pop <= quiet || ($urandom_range(99) >= 7);
            end
        end
    end

    // watchdog on cycles with no request moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_percent_decoder: done, errors");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] c, input logic eos);
        @(negedge clk);
        if (!quiet)
        begin
            while ($urandom_range(99) < 7)
            begin
                push <= 1'b0;
                @(negedge clk);
            end
        end
        push          <= 1'b1;
        char_in       <= c;
        end_of_string <= eos;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        bytes_sent++;
        if (eos)
        begin
            strings_sent++;
        end
    endtask

    task automatic send_literal(input string s, input bit eos_last);
        for (int i = 0; i < s.len(); i++)
        begin
            send_byte(s[i], eos_last && (i == s.len() - 1));
        end
    endtask

    task automatic send_text();
        for (int i = 0; i < text.size(); i++)
        begin
            send_byte(text[i], i == text.size() - 1);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        push <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] hex_char();
        int r;
        r = $urandom_range(21);
        if (r < 10)
        begin
            return 8'h30 + 8'(r);
        end
        if (r < 16)
        begin
            return 8'h41 + 8'(r - 10);
        end
        return 8'h61 + 8'(r - 16);
    endfunction

    // bytes just outside the hex ranges, a percent sign, or anything at all
    function automatic logic [7:0] odd_char();
        case ($urandom_range(7))
            0: return 8'h2F;
            1: return 8'h3A;
            2: return 8'h40;
            3: return 8'h47;
            4: return 8'h60;
            5: return 8'h67;
            6: return PCT_CHAR;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // well-formed and bad escapes, lone percent signs and random bytes; truncation to len cuts some escapes short
    task automatic make_text();
        int len;
        int kind;
        len = ($urandom_range(9) == 0) ? $urandom_range(24, 13) : $urandom_range(8, 1);
        text.delete();
        while (text.size() < len)
        begin
            kind = $urandom_range(99);
            if (kind < 40)
            begin
                text.push_back(PCT_CHAR);
                text.push_back(hex_char());
                text.push_back(hex_char());
            end
            else if (kind < 55)
            begin
                text.push_back(PCT_CHAR);
                if ($urandom_range(1))
                begin
                    text.push_back(odd_char());
                    text.push_back($urandom_range(1) ? hex_char() : odd_char());
                end
                else
                begin
                    text.push_back(hex_char());
                    text.push_back(odd_char());
                end
            end
            else if (kind < 60)
            begin
                text.push_back(PCT_CHAR);
            end
            else
            begin
                text.push_back(8'($urandom_range(255)));
            end
        end
        while (text.size() > len)
        begin
            void'(text.pop_back());
        end
    endtask

    initial
    begin
        int  directed_cnt;
        bit  held_once;
        bit  drained_once;
        held_once    = 1'b0;
        drained_once = 1'b0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_literal("%41", 1'b0);
        send_literal("%6a", 1'b0);
        send_literal("%Ff", 1'b0);
        send_literal("%00", 1'b0);
        send_literal("%g1", 1'b0);
        send_literal("%1z", 1'b1);
        send_literal("%4", 1'b1);
        send_literal("%", 1'b1);
        send_byte(8'h41, 1'b1);
        wait_drained();
        directed_cnt = bytes_sent;

        while (bytes_sent < directed_cnt + N_RANDOM)
        begin
            if (!held_once && bytes_sent >= directed_cnt + 150)
            begin
                hold_requests++;
                held_once = 1'b1;
            end
            if (!drained_once && bytes_sent >= directed_cnt + 600)
            begin
                wait_drained();
                drained_once = 1'b1;
            end
            quiet = (bytes_sent >= directed_cnt + 300) && (bytes_sent < directed_cnt + 480);
            make_text();
            send_text();
        end
        quiet = 1'b0;
        wait_drained();

        $display("covered %0d bytes in %0d strings, %0d results checked", bytes_sent,
                 strings_sent, checked);
        $display("escapes good, bad and cut short; receiver hold-off and sender drain done");
        if (errors == 0 && outstanding == 0)
        begin
            $display("tb_percent_decoder: done, clean");
        end
        else
        begin
            $display("tb_percent_decoder: done, errors");
        end
        $finish;
    end

endmodule
